>>> src/ogmaf_pkg.sv
package ogmaf_pkg;

   localparam int DATA_W = 32;
   localparam int WIN_W = 31;
   localparam int DIGIT_W = 8;
   localparam int CSR_ADDR_W = 3;

   localparam logic CSR_WINDOW = 1'b0;
   localparam logic CSR_MODE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WRITE,
      ST_SWEEP,
      ST_DRAIN,
      ST_DIVIDE,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic negative;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

>>> src/outlier_gated_median_average_filter.sv
// Path when the sample joins the ring: one write, one read per ring entry, the median/sum
//   pipeline, then the 8-bit-per-cycle divider; on a restart, one ring write per entry;
//   otherwise the result is registered directly.
// Flow: one sample at a time; the next transaction is taken the cycle after the result is
//   registered.
// Reset: synchronous; ring reads as zero through per-entry valid bits, average, previous
//   sample, write slot and accept_window clear, median_mode sets.
module outlier_gated_median_average_filter #(
   parameter int RING_DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ogmaf_pkg::DATA_W-1:0]   req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ogmaf_pkg::DATA_W-1:0]   rsp_filtered_value,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ogmaf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   localparam int DW = ogmaf_pkg::DATA_W;
   localparam int AW = $clog2(RING_DEPTH);
   localparam int SLOT_W = $clog2(RING_DEPTH + 1);
   localparam int DIVISOR = RING_DEPTH - 2;
   localparam int SUM_W = DW + AW + 1;
   localparam int DVD_W = ((SUM_W + ogmaf_pkg::DIGIT_W - 1) / ogmaf_pkg::DIGIT_W)
                          * ogmaf_pkg::DIGIT_W;
   localparam int LAST = RING_DEPTH - 1;

   ogmaf_pkg::state_type state_ff, state_in;

   logic signed [DW-1:0]         s_ff;
   logic signed [DW-1:0]         prev_ff;
   logic signed [DW-1:0]         avg_ff;
   logic [SLOT_W-1:0]            slot_ff;
   logic [ogmaf_pkg::WIN_W-1:0]  window_ff;
   logic                         mode_ff;
   logic [AW-1:0]                cnt_ff;
   logic [RING_DEPTH-1:0]        ring_vld_ff;
   logic                         rd_live_ff;
   logic [AW-1:0]                rd_idx_ff;
   logic                         rd_vld_ff;
   logic signed [DW-1:0]         win_a_ff;
   logic signed [DW-1:0]         win_b_ff;
   logic signed [DW-1:0]         med_ff;
   logic                         med_live_ff;
   logic signed [SUM_W-1:0]      sum_ff;
   logic                         rsp_valid_ff;
   logic signed [DW-1:0]         rsp_data_ff;

   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [DW-1:0]                ram_wdata;
   logic [DW-1:0]                ram_q;
   logic signed [DW-1:0]         rd_value;
   logic                         rd_issue;

   logic signed [DW:0]           d_avg;
   logic signed [DW:0]           d_prev;
   logic [DW:0]                  abs_avg;
   logic [DW:0]                  abs_prev;
   logic                         near_avg;
   logic                         near_prev;
   logic signed [DW:0]           pair;
   logic signed [DW:0]           pair_adj;
   logic signed [DW-1:0]         mean_val;
   logic [AW-1:0]                wslot;
   logic                         out_free;
   logic                         csr_wr;
   logic [SUM_W-1:0]             sum_mag;

   ogmaf_pkg::div_ctrl_type      div_ctrl;
   ogmaf_pkg::div_status_type    div_status;
   logic [DW-1:0]                div_quotient;

   function automatic logic signed [DW-1:0] mid3(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b,
                                                 input logic signed [DW-1:0] c);
      logic signed [DW-1:0] m;
      if ((a < b && a > c) || (a > b && a < c)) begin
         m = a;
      end else if ((b < a && b > c) || (b > a && b < c)) begin
         m = b;
      end else begin
         m = c;
      end
      return m;
   endfunction

   ogmaf_ram #(
      .WIDTH(DW),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cnt_ff),
      .rd_data (ram_q)
   );

   ogmaf_div #(
      .DVD_W   (DVD_W),
      .DIVISOR (DIVISOR)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (DVD_W'(sum_mag)),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign d_avg = {avg_ff[DW-1], avg_ff} - {s_ff[DW-1], s_ff};
   assign d_prev = {prev_ff[DW-1], prev_ff} - {s_ff[DW-1], s_ff};
   assign abs_avg = d_avg[DW] ? (DW+1)'(-d_avg) : (DW+1)'(d_avg);
   assign abs_prev = d_prev[DW] ? (DW+1)'(-d_prev) : (DW+1)'(d_prev);
   assign near_avg = abs_avg <= (DW+1)'(window_ff);
   assign near_prev = abs_prev < (DW+1)'(window_ff);

   assign pair = {prev_ff[DW-1], prev_ff} + {s_ff[DW-1], s_ff};
   assign pair_adj = pair + ((DW+1)'(pair[DW]));
   assign mean_val = pair_adj[DW:1];

   assign wslot = (slot_ff >= SLOT_W'(RING_DEPTH)) ? '0 : slot_ff[AW-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_value = rd_vld_ff ? ram_q : '0;
   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ogmaf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ram_we = 1'b0;
      ram_waddr = cnt_ff;
      ram_wdata = s_ff;
      rd_issue = 1'b0;
      div_ctrl.start = 1'b0;
      div_ctrl.negative = sum_ff[SUM_W-1];
      unique case (state_ff)
         ogmaf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ogmaf_pkg::ST_DECIDE;
            end
         end
         ogmaf_pkg::ST_DECIDE: begin
            if (near_avg) begin
               state_in = ogmaf_pkg::ST_WRITE;
            end else if (near_prev) begin
               state_in = ogmaf_pkg::ST_FILL;
            end else begin
               state_in = ogmaf_pkg::ST_DONE;
            end
         end
         ogmaf_pkg::ST_WRITE: begin
            ram_we = 1'b1;
            ram_waddr = wslot;
            state_in = ogmaf_pkg::ST_SWEEP;
         end
         ogmaf_pkg::ST_SWEEP: begin
            rd_issue = 1'b1;
            if (cnt_ff == AW'(LAST)) begin
               state_in = ogmaf_pkg::ST_DRAIN;
            end
         end
         ogmaf_pkg::ST_DRAIN: begin
            if (!rd_live_ff && !med_live_ff) begin
               div_ctrl.start = 1'b1;
               state_in = ogmaf_pkg::ST_DIVIDE;
            end
         end
         ogmaf_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ogmaf_pkg::ST_DONE;
            end
         end
         ogmaf_pkg::ST_FILL: begin
            ram_we = 1'b1;
            ram_wdata = (cnt_ff == '0) ? prev_ff : s_ff;
            if (cnt_ff == AW'(LAST)) begin
               state_in = ogmaf_pkg::ST_DONE;
            end
         end
         ogmaf_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ogmaf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ogmaf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         avg_ff       <= '0;
         slot_ff      <= '0;
         window_ff    <= '0;
         mode_ff      <= 1'b1;
         ring_vld_ff  <= '0;
         rd_live_ff   <= 1'b0;
         med_live_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            unique case (csr_paddr[2])
               ogmaf_pkg::CSR_WINDOW: window_ff <= csr_pwdata[ogmaf_pkg::WIN_W-1:0];
               ogmaf_pkg::CSR_MODE:   mode_ff <= csr_pwdata[0];
               default:               window_ff <= window_ff;
            endcase
         end

         if (state_ff == ogmaf_pkg::ST_IDLE && req_valid) begin
            s_ff <= req_sample;
         end

         if (state_ff == ogmaf_pkg::ST_DECIDE) begin
            cnt_ff <= '0;
         end else if (state_ff == ogmaf_pkg::ST_SWEEP || state_ff == ogmaf_pkg::ST_FILL) begin
            cnt_ff <= cnt_ff + AW'(1);
         end

         if (ram_we) begin
            ring_vld_ff[ram_waddr] <= 1'b1;
         end

         if (state_ff == ogmaf_pkg::ST_WRITE) begin
            slot_ff <= SLOT_W'(wslot) + SLOT_W'(1);
            sum_ff  <= '0;
         end

         if (state_ff == ogmaf_pkg::ST_FILL && cnt_ff == AW'(LAST)) begin
            slot_ff <= SLOT_W'(1);
            avg_ff  <= mean_val;
         end

         rd_live_ff <= rd_issue;
         rd_idx_ff  <= cnt_ff;
         rd_vld_ff  <= ring_vld_ff[cnt_ff];

         if (rd_live_ff) begin
            win_a_ff    <= win_b_ff;
            win_b_ff    <= rd_value;
            med_live_ff <= rd_idx_ff >= AW'(2);
            med_ff      <= mode_ff ? mid3(win_a_ff, win_b_ff, rd_value) : win_a_ff;
         end else begin
            med_live_ff <= 1'b0;
         end

         if (med_live_ff) begin
            sum_ff <= sum_ff + SUM_W'(med_ff);
         end

         if (state_ff == ogmaf_pkg::ST_DIVIDE && div_status.done) begin
            avg_ff <= div_quotient;
         end

         if (state_ff == ogmaf_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= avg_ff;
            prev_ff      <= s_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = state_ff != ogmaf_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered_value = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ogmaf_pkg::CSR_MODE) ? {31'd0, mode_ff}
                                                               : {1'b0, window_ff};

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(RING_DEPTH))
      else $error("write slot past ring depth");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == ogmaf_pkg::ST_DIVIDE)
      else $error("divider busy outside divide state");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ogmaf_pkg::ST_DONE))
      else $error("result raised without finishing a transaction");

   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ogmaf_pkg::ST_DECIDE)
      else $error("accepted transaction not decided next cycle");

endmodule

>>> src/ogmaf_ram.sv
module ogmaf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> src/ogmaf_div.sv
module ogmaf_div #(
   parameter int DVD_W = 40,
   parameter int DIVISOR = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ogmaf_pkg::div_ctrl_type         ctrl,
   input  logic [DVD_W-1:0]                dividend,
   output ogmaf_pkg::div_status_type       status,
   output logic [ogmaf_pkg::DATA_W-1:0]    quotient
);

   localparam int NSTEP = DVD_W / ogmaf_pkg::DIGIT_W;
   localparam int CNT_W = $clog2(NSTEP + 1);
   localparam int REM_W = $clog2(DIVISOR + 1);

   logic                          busy_ff;
   logic                          done_ff;
   logic                          neg_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic [DVD_W-1:0]              dvd_ff;
   logic [DVD_W-1:0]              quo_ff;
   logic [REM_W-1:0]              rem_ff;
   logic [REM_W-1:0]              rem_in;
   logic [ogmaf_pkg::DIGIT_W-1:0] digit_in;

   always_comb begin
      logic [REM_W:0]   trial;
      logic [REM_W-1:0] rem_v;
      rem_v = rem_ff;
      digit_in = '0;
      for (int i = 0; i < ogmaf_pkg::DIGIT_W; i++) begin
         trial = {rem_v, dvd_ff[DVD_W-1-i]};
         if (trial >= (REM_W+1)'(DIVISOR)) begin
            rem_v = REM_W'(trial - (REM_W+1)'(DIVISOR));
            digit_in[ogmaf_pkg::DIGIT_W-1-i] = 1'b1;
         end else begin
            rem_v = trial[REM_W-1:0];
         end
      end
      rem_in = rem_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= dividend;
            quo_ff  <= '0;
            rem_ff  <= '0;
            neg_ff  <= ctrl.negative;
         end else if (busy_ff) begin
            dvd_ff <= dvd_ff << ogmaf_pkg::DIGIT_W;
            quo_ff <= {quo_ff[DVD_W-ogmaf_pkg::DIGIT_W-1:0], digit_in};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NSTEP - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient = neg_ff ? -quo_ff[ogmaf_pkg::DATA_W-1:0] : quo_ff[ogmaf_pkg::DATA_W-1:0];

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int RING_DEPTH = 8;
   localparam int ROWS = 25;
   localparam longint RUN_LIMIT_NS = 2_000_000;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic               csr_index;
      logic [31:0]        value;
      bit                 fixed;
      logic signed [31:0] expected;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [ogmaf_pkg::DATA_W-1:0] req_sample;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [ogmaf_pkg::DATA_W-1:0] rsp_filtered_value;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [ogmaf_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   bit req_fixed;
   logic signed [31:0] req_fixed_value;

   logic signed [31:0] hist_ring [RING_DEPTH] = '{default: '0};
   int hist_slot = 0;
   logic signed [31:0] hist_average = '0;
   logic signed [31:0] hist_previous = '0;
   logic [ogmaf_pkg::WIN_W-1:0] win_setting = '0;
   logic mode_setting = 1'b1;

   logic signed [31:0] filtered_expected [$];
   int err_count = 0;
   int gap_max = 17;
   int stall_max = 17;

   stim_row_type directed_rows [ROWS] = '{
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'h0000_0000, 1'b1, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'h0000_0001, 1'b1, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'h8000_0000, 1'b1, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'h7FFF_FFFF, 1'b1, 32'sd0},
      '{ROW_CSR,    ogmaf_pkg::CSR_WINDOW, 32'd100,       1'b0, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'd5000,      1'b1, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'd5050,      1'b1, 32'sd5025},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'd5125,      1'b0, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, -32'sd5000,    1'b0, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, -32'sd5099,    1'b1, -32'sd5049},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, -32'sd5199,    1'b1, -32'sd5049},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, -32'sd5149,    1'b0, 32'sd0},
      '{ROW_CSR,    ogmaf_pkg::CSR_MODE,   32'd0,         1'b0, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, -32'sd5100,    1'b0, 32'sd0},
      '{ROW_CSR,    ogmaf_pkg::CSR_WINDOW, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'h8000_0000, 1'b0, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'h0000_0000, 1'b0, 32'sd0},
      '{ROW_CSR,    ogmaf_pkg::CSR_MODE,   32'd1,         1'b0, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'h8000_0000, 1'b0, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'h7FFF_FFFF, 1'b0, 32'sd0},
      '{ROW_SAMPLE, ogmaf_pkg::CSR_WINDOW, 32'h7FFF_FFFF, 1'b0, 32'sd0}
   };

   outlier_gated_median_average_filter #(
      .RING_DEPTH(RING_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_filtered_value(rsp_filtered_value),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic signed [31:0] mid_of_three(input logic signed [31:0] a,
                                                       input logic signed [31:0] b,
                                                       input logic signed [31:0] c);
      if ((a < b && a > c) || (a > b && a < c))
         return a;
      if ((b < a && b > c) || (b > a && b < c))
         return b;
      return c;
   endfunction

   function automatic longint distance(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return (d < 0) ? -d : d;
   endfunction

   function automatic logic signed [31:0] next_filtered_value(input logic signed [31:0] s);
      longint sum;
      if (distance(hist_average, s) <= longint'(win_setting)) begin
         if (hist_slot >= RING_DEPTH)
            hist_slot = 0;
         hist_ring[hist_slot] = s;
         hist_slot++;
         sum = 0;
         for (int i = 0; i < RING_DEPTH - 2; i++) begin
            if (mode_setting)
               sum += longint'(mid_of_three(hist_ring[i], hist_ring[i + 1], hist_ring[i + 2]));
            else
               sum += longint'(hist_ring[i]);
         end
         sum = sum / longint'(RING_DEPTH - 2);
         hist_average = sum[31:0];
      end else if (distance(hist_previous, s) < longint'(win_setting)) begin
         hist_ring[0] = hist_previous;
         for (int i = 1; i < RING_DEPTH; i++)
            hist_ring[i] = s;
         hist_slot = 1;
         sum = (longint'(s) + longint'(hist_previous)) / 2;
         hist_average = sum[31:0];
      end
      hist_previous = s;
      return hist_average;
   endfunction

   // mostly samples near the average or the previous sample, some on the window edge
   function automatic logic signed [31:0] pick_sample();
      int unsigned pick;
      int unsigned span;
      longint base;
      longint v;
      pick = $urandom_range(0, 99);
      span = 32'(win_setting);
      if (pick < 15)
         return $urandom;
      base = (pick < 70 || pick >= 95) ? longint'(hist_average) : longint'(hist_previous);
      if (pick < 90) begin
         v = base + longint'($urandom_range(0, 2 * span)) - longint'(span);
      end else begin
         v = longint'(span) + longint'($urandom_range(0, 2)) - 1;
         if ($urandom_range(0, 1))
            v = -v;
         v = base + v;
      end
      if (v > 64'sd2147483647)
         v = 64'sd2147483647;
      if (v < -64'sd2147483648)
         v = -64'sd2147483648;
      return v[31:0];
   endfunction

   always @(posedge clock) begin : monitor
      logic signed [31:0] want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (filtered_expected.size() == 0) begin
               $display("%0t: unexpected filtered_value %0d, none expected", $time,
                        rsp_filtered_value);
               err_count++;
            end else begin
               want = filtered_expected.pop_front();
               if (rsp_filtered_value !== want) begin
                  $display("%0t: filtered_value mismatch: expected %0d, actual %0d", $time,
                           want, rsp_filtered_value);
                  err_count++;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == {ogmaf_pkg::CSR_WINDOW, 2'b00})
               win_setting = csr_pwdata[ogmaf_pkg::WIN_W-1:0];
            else if (csr_paddr == {ogmaf_pkg::CSR_MODE, 2'b00})
               mode_setting = csr_pwdata[0];
         end
         if (req_valid && !req_stall) begin
            want = next_filtered_value(req_sample);
            filtered_expected.push_back(req_fixed ? req_fixed_value : want);
         end
      end
   end

   initial begin : receiver
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         n = $urandom_range(0, stall_max);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   task automatic drive_sample(input logic signed [31:0] value, input bit fixed,
                               input logic signed [31:0] expected);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_sample <= value;
      req_fixed <= fixed;
      req_fixed_value <= expected;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (filtered_expected.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_register(input logic index, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] got;
      mask = (index == ogmaf_pkg::CSR_WINDOW) ? 32'h7FFF_FFFF : 32'h0000_0001;
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      if ((got & mask) !== (value & mask)) begin
         $display("%0t: register %0d readback mismatch: expected %0h, actual %0h", $time,
                  index, value & mask, got & mask);
         err_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      #(RUN_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] window;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_fixed = 1'b0;
      req_fixed_value = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_register(directed_rows[i].csr_index, directed_rows[i].value);
         end else begin
            drive_sample(directed_rows[i].value, directed_rows[i].fixed,
                         directed_rows[i].expected);
         end
      end

      for (int phase = 0; phase < 19; phase++) begin
         wait_idle();
         case (phase % 6)
            0: window = 32'h0000_0000;
            1: window = 32'h7FFF_FFFF;
            2: window = $urandom_range(1, 8);
            3: window = $urandom_range(9, 1000);
            4: window = $urandom & 32'h7FFF_FFFF;
            default: window = 32'h1 << $urandom_range(0, 30);
         endcase
         write_register(ogmaf_pkg::CSR_WINDOW, window);
         write_register(ogmaf_pkg::CSR_MODE, phase % 2);
         gap_max = (phase % 4 == 3) ? 0 : 17;
         stall_max = (phase % 4 == 3) ? 0 : 17;
         for (int k = 0; k < 100; k++) begin
            if ($urandom_range(0, 49) == 0)
               wait_idle();
            drive_sample(pick_sample(), 1'b0, 32'sd0);
         end
      end

      wait_idle();
      repeat (40) @(negedge clock);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> files.f
src/ogmaf_pkg.sv
src/ogmaf_ram.sv
src/ogmaf_div.sv
src/outlier_gated_median_average_filter.sv
dv/tb_top.sv
